@@ rtl/lfla_pkg.sv @@
// Package for the lowest free link allocator: word types, the control bundle
// shared by the link cells and the link count constants. No dependencies.
package lfla_pkg;

    localparam int LINKS      = 64;
    localparam int TIME_W     = 31;
    localparam int LINK_NUM_W = 6;
    localparam int LINK_IDX_W = (LINKS > 1) ? $clog2(LINKS) : 1;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
    } in_word_t;

    typedef struct packed {
        logic [LINK_NUM_W-1:0] link_number;
        logic                  granted;
    } out_word_t;

    // Broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic              release_en;
        logic              grant_en;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_GRANT
    } lfla_state_t;

    // Keeps the low bits of a link index, zero-extending narrow indexes.
    function automatic logic [LINK_NUM_W-1:0] to_link_number(
        input logic [LINK_IDX_W-1:0] idx
    );
        logic [LINK_IDX_W+LINK_NUM_W-1:0] wide;
        wide = (LINK_IDX_W + LINK_NUM_W)'(idx);
        return wide[LINK_NUM_W-1:0];
    endfunction

endpackage

@@ rtl/lowest_free_link_allocator.sv @@
// Lowest free link allocator. A new word is taken only after the last one has
// been granted: links are released at the accepting edge, and the grant, made
// in the grant state once the output register is free, loads the result word.
// A result held by m_ready low stalls the grant and the input; the claim chain
// through the row of cells picks the granted link. Reset frees every link;
// stored release times are left as they are and are only read for busy links.
module lowest_free_link_allocator import lfla_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    lfla_state_t           state_reg;
    lfla_state_t           state_next;
    logic [TIME_W-1:0]     end_time_reg;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    out_word_t             m_data_reg;
    cell_ctrl_t            ctrl;
    logic                  any_free;
    logic [LINK_IDX_W-1:0] pick_idx;
    logic                  out_free;
    logic                  accept;
    logic                  load_out;

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    always_comb begin
        state_next       = state_reg;
        s_ready          = 1'b0;
        load_out         = 1'b0;
        ctrl.release_en  = 1'b0;
        ctrl.grant_en    = 1'b0;
        ctrl.start_time  = s_data.start_time;
        ctrl.end_time    = end_time_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready         = 1'b1;
                ctrl.release_en = s_valid;
                if (s_valid) begin
                    state_next = ST_GRANT;
                end
            end
            ST_GRANT: begin
                // Hold the grant until the output register can take the word.
                if (out_free) begin
                    ctrl.grant_en = 1'b1;
                    load_out      = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            end_time_reg <= s_data.end_time;
        end
        if (load_out) begin
            m_data_reg.granted     <= any_free;
            m_data_reg.link_number <= any_free ? to_link_number(pick_idx) : '0;
        end
    end

    lfla_row u_row (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .any_free (any_free),
        .pick_idx (pick_idx)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/lfla_cell.sv @@
// One link cell: busy flag and release time for a single link.
// Depends on lfla_pkg for the control bundle and widths.
module lfla_cell import lfla_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  logic       taken_in,
    output logic       taken_out,
    output logic       pick
);

    logic              busy_reg;
    logic              busy_next;
    logic [TIME_W-1:0] release_time_reg;

    // A free cell claims the request unless a lower cell has already done so.
    assign pick      = !busy_reg && !taken_in;
    assign taken_out = taken_in || !busy_reg;

    always_comb begin
        busy_next = busy_reg;
        if (ctrl.release_en && busy_reg && (release_time_reg <= ctrl.start_time)) begin
            busy_next = 1'b0;
        end
        if (ctrl.grant_en && pick) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.grant_en && pick) begin
            release_time_reg <= ctrl.end_time;
        end
    end

endmodule

@@ rtl/lfla_row.sv @@
// Row of link cells joined by the claim chain, with the index encoder.
// Depends on lfla_pkg and lfla_cell.
module lfla_row import lfla_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cell_ctrl_t            ctrl,
    output logic                  any_free,
    output logic [LINK_IDX_W-1:0] pick_idx
);

    logic [LINKS:0]   taken;
    logic [LINKS-1:0] pick;

    assign taken[0] = 1'b0;

    for (genvar i = 0; i < LINKS; i++) begin : g_cell
        lfla_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .taken_in  (taken[i]),
            .taken_out (taken[i+1]),
            .pick      (pick[i])
        );
    end

    assign any_free = taken[LINKS];

    // At most one cell picks, so the index bits can simply be ORed together.
    always_comb begin
        pick_idx = '0;
        for (int i = 0; i < LINKS; i++) begin
            if (pick[i]) begin
                pick_idx = pick_idx | LINK_IDX_W'(i);
            end
        end
    end

endmodule
